FILE: rtl/core/plsa_pkg.sv
package plsa_pkg;

    localparam int COORD_W = 32;
    localparam int TOTAL_W = 64;
    localparam int COUNT_W = 5;
    localparam int SLOT_W  = 4;
    localparam int OP_W    = 2;
    localparam int PROD_W  = 2 * COORD_W;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [TOTAL_W-1:0] total_t;
    typedef logic [COUNT_W-1:0]        count_t;
    typedef logic [SLOT_W-1:0]         slot_t;
    typedef logic [OP_W-1:0]           op_t;
    typedef logic [PROD_W-1:0]         prod_t;

    localparam op_t OP_EVALUATE = 2'd0;
    localparam op_t OP_WRITE    = 2'd1;
    localparam op_t OP_CLEAR    = 2'd2;

    typedef logic [1:0] score_sel_t;

    localparam score_sel_t SEL_ZERO   = 2'd0;
    localparam score_sel_t SEL_CUR_Y  = 2'd1;
    localparam score_sel_t SEL_INTERP = 2'd2;

    typedef struct packed {
        logic       start;
        logic       wr_entry;
        logic       clear_sum;
        logic       load_cur;
        logic       advance;
        logic       latch_seg;
        logic       div_start;
        logic       set_score;
        score_sel_t score_sel;
        logic       emit;
    } ctl_cmd_t;

    typedef struct packed {
        logic below;
        logic last;
        logic beyond;
        logic zero_width;
        logic div_busy;
        logic div_done;
        logic out_full;
    } ctl_status_t;

endpackage

FILE: rtl/core/plsa_if.sv
interface plsa_item_if import plsa_pkg::*;;
    logic   valid;
    logic   ready;
    op_t    operation;
    slot_t  entry_slot;
    coord_t in_x;
    coord_t in_y;

    modport source (output valid, operation, entry_slot, in_x, in_y, input ready);
    modport sink (input valid, operation, entry_slot, in_x, in_y, output ready);
endinterface

interface plsa_result_if import plsa_pkg::*;;
    logic   valid;
    logic   ready;
    coord_t score;
    total_t running_total;

    modport source (output valid, score, running_total, input ready);
    modport sink (input valid, score, running_total, output ready);
endinterface

interface plsa_cfg_if import plsa_pkg::*;;
    logic   valid;
    logic   ready;
    count_t points_in_use;

    modport source (output valid, points_in_use, input ready);
    modport sink (input valid, points_in_use, output ready);
endinterface

FILE: rtl/core/piecewise_linear_score_accumulator.sv
// Channel  Role   Payload
// item     sink   operation, entry_slot, in_x, in_y
// result   source score, running_total
// cfg      sink   points_in_use (always ready)
//
// Write and clear items complete at their transfer; an item with operation 3 is dropped.
// An evaluate item walks the segments one at a time and shows its result when it stops at a
// breakpoint, meets a zero-width segment or interpolates with the 64-step serial divider;
// the next item can be taken in the cycle the result shows.
// Reset clears the accumulator and sets points_in_use to 1; the table holds garbage.
// A finished result waits in the output register while the next item is taken.
module piecewise_linear_score_accumulator import plsa_pkg::*; #(
    parameter int MAX_POINTS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    plsa_item_if.sink          item,
    plsa_result_if.source      result,
    plsa_cfg_if.sink           cfg
);

    ctl_cmd_t    dp_cmd;
    ctl_status_t dp_status;
    logic        item_ready;

    assign item.ready = item_ready;
    assign cfg.ready  = 1'b1;

    plsa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .operation  (item.operation),
        .item_ready (item_ready),
        .status     (dp_status),
        .cmd        (dp_cmd)
    );

    plsa_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (dp_cmd),
        .status        (dp_status),
        .entry_slot    (item.entry_slot),
        .in_x          (item.in_x),
        .in_y          (item.in_y),
        .cfg_valid     (cfg.valid),
        .cfg_points    (cfg.points_in_use),
        .result_ready  (result.ready),
        .result_valid  (result.valid),
        .score         (result.score),
        .running_total (result.running_total)
    );

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(dp_cmd.emit))
    else $error("Result valid rose without an emit command.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |-> !dp_status.div_busy)
    else $error("Item transfer taken while the divider is busy.");

    assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.emit |=> (result.valid && $past(!dp_status.out_full)))
    else $error("Emit overwrote a result that was still waiting.");
`endif

endmodule

FILE: rtl/core/plsa_ram.sv
module plsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/plsa_div.sv
module plsa_div import plsa_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  prod_t                dividend,
    input  logic [COORD_W-1:0]   divisor,
    output logic                 busy,
    output logic                 done,
    output logic [COORD_W-1:0]   quotient
);

    localparam int STEPS = PROD_W;
    localparam int CNT_W = $clog2(STEPS);

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic [COORD_W-1:0]   rem_reg;
    logic [COORD_W-1:0]   rem_next;
    prod_t                quo_reg;
    prod_t                quo_next;
    logic [COORD_W-1:0]   div_reg;
    logic [COORD_W-1:0]   div_next;
    logic [COORD_W:0]     trial;
    logic [COORD_W:0]     diff;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[PROD_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
            quo_next = {quo_reg[PROD_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg[COORD_W-1:0];

endmodule

FILE: rtl/core/plsa_datapath.sv
module plsa_datapath import plsa_pkg::*; #(
    parameter int MAX_POINTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  ctl_cmd_t    cmd,
    output ctl_status_t status,
    input  slot_t       entry_slot,
    input  coord_t      in_x,
    input  coord_t      in_y,
    input  logic        cfg_valid,
    input  count_t      cfg_points,
    input  logic        result_ready,
    output logic        result_valid,
    output coord_t      score,
    output total_t      running_total
);

    localparam int IW = $clog2(MAX_POINTS);

    count_t               points_reg;
    logic [IW-1:0]        last_idx;
    logic [IW-1:0]        idx_reg;
    logic [IW-1:0]        raddr;
    logic                 wr_en;
    logic [PROD_W-1:0]    rdata;
    coord_t               next_x;
    coord_t               next_y;
    coord_t               eval_x_reg;
    coord_t               cur_x_reg;
    coord_t               cur_y_reg;
    logic [COORD_W-1:0]   dx_reg;
    logic [COORD_W-1:0]   w_reg;
    logic [COORD_W-1:0]   mag_reg;
    logic                 neg_reg;
    logic [COORD_W:0]     dx_wide;
    logic [COORD_W:0]     w_wide;
    logic signed [COORD_W:0] dy_wide;
    logic [COORD_W:0]     mag_wide;
    prod_t                product;
    logic                 div_busy;
    logic                 div_done;
    logic [COORD_W-1:0]   quotient;
    coord_t               score_reg;
    coord_t               score_next;
    total_t               sum_reg;
    total_t               sum_next;
    logic                 result_valid_reg;
    coord_t               result_score_reg;
    total_t               result_total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            points_reg <= COUNT_W'(1);
        end
        else if (cfg_valid)
        begin
            points_reg <= cfg_points;
        end
    end

    always_comb
    begin
        if (points_reg == '0)
        begin
            last_idx = '0;
        end
        else if (int'(points_reg) > MAX_POINTS)
        begin
            last_idx = IW'(MAX_POINTS - 1);
        end
        else
        begin
            last_idx = IW'(points_reg - 1'b1);
        end
    end

    assign wr_en = cmd.wr_entry && (int'(entry_slot) < MAX_POINTS);
    assign raddr = cmd.start ? '0 : IW'(idx_reg + 1'b1);

    plsa_ram #(
        .WIDTH (PROD_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (IW'(entry_slot)),
        .wdata ({in_x, in_y}),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign next_x = rdata[PROD_W-1:COORD_W];
    assign next_y = rdata[COORD_W-1:0];

    assign dx_wide  = {eval_x_reg[COORD_W-1], eval_x_reg} - {cur_x_reg[COORD_W-1], cur_x_reg};
    assign w_wide   = {next_x[COORD_W-1], next_x} - {cur_x_reg[COORD_W-1], cur_x_reg};
    assign dy_wide  = {next_y[COORD_W-1], next_y} - {cur_y_reg[COORD_W-1], cur_y_reg};
    assign mag_wide = dy_wide[COORD_W] ? -dy_wide : dy_wide;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (cmd.start)
        begin
            idx_reg <= '0;
        end
        else if (cmd.advance)
        begin
            idx_reg <= IW'(idx_reg + 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            eval_x_reg <= in_x;
        end
        if (cmd.load_cur || cmd.advance)
        begin
            cur_x_reg <= next_x;
            cur_y_reg <= next_y;
        end
        if (cmd.latch_seg)
        begin
            dx_reg  <= dx_wide[COORD_W-1:0];
            w_reg   <= w_wide[COORD_W-1:0];
            mag_reg <= mag_wide[COORD_W-1:0];
            neg_reg <= dy_wide[COORD_W];
        end
    end

    assign product = PROD_W'(dx_reg) * PROD_W'(mag_reg);

    plsa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (product),
        .divisor  (w_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        case (cmd.score_sel)
            SEL_CUR_Y:  score_next = cur_y_reg;
            SEL_INTERP: score_next = neg_reg ? cur_y_reg - $signed(quotient)
                                             : cur_y_reg + $signed(quotient);
            default:    score_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.set_score)
        begin
            score_reg <= score_next;
        end
    end

    assign sum_next = sum_reg + {{(TOTAL_W-COORD_W){score_reg[COORD_W-1]}}, score_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_sum)
            begin
                sum_reg <= '0;
            end
            else if (cmd.emit)
            begin
                sum_reg <= sum_next;
            end
            if (cmd.emit)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result_score_reg <= score_reg;
            result_total_reg <= sum_next;
        end
    end

    assign status.below      = eval_x_reg < cur_x_reg;
    assign status.last       = idx_reg == last_idx;
    assign status.beyond     = eval_x_reg > next_x;
    assign status.zero_width = next_x == cur_x_reg;
    assign status.div_busy   = div_busy;
    assign status.div_done   = div_done;
    assign status.out_full   = result_valid_reg && !result_ready;

    assign result_valid  = result_valid_reg;
    assign score         = result_score_reg;
    assign running_total = result_total_reg;

endmodule

FILE: rtl/core/plsa_ctrl.sv
module plsa_ctrl import plsa_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  op_t         operation,
    output logic        item_ready,
    input  ctl_status_t status,
    output ctl_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOAD   = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_FETCH  = 3'd3;
    localparam logic [2:0] S_MUL    = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign item_ready = state_reg == S_IDLE;
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (operation)
                        OP_EVALUATE:
                        begin
                            cmd.start  = 1'b1;
                            state_next = S_LOAD;
                        end
                        OP_WRITE: cmd.wr_entry  = 1'b1;
                        OP_CLEAR: cmd.clear_sum = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_LOAD:
            begin
                cmd.load_cur = 1'b1;
                state_next   = S_CHECK;
            end
            S_CHECK:
            begin
                if (status.below)
                begin
                    cmd.set_score = 1'b1;
                    cmd.score_sel = SEL_ZERO;
                    state_next    = S_FINISH;
                end
                else if (status.last)
                begin
                    cmd.set_score = 1'b1;
                    cmd.score_sel = SEL_CUR_Y;
                    state_next    = S_FINISH;
                end
                else
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                if (status.beyond)
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_CHECK;
                end
                else if (status.zero_width)
                begin
                    cmd.set_score = 1'b1;
                    cmd.score_sel = SEL_CUR_Y;
                    state_next    = S_FINISH;
                end
                else
                begin
                    cmd.latch_seg = 1'b1;
                    state_next    = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.set_score = 1'b1;
                    cmd.score_sel = SEL_INTERP;
                    state_next    = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!status.out_full)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
